// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL of the padded FFT size block.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- hdl/fsp_pkg.sv -----
// Shared types and constants for the padded FFT size block.
// No dependencies; every other file of the block but assert_macros.svh imports this package.
package fsp_pkg;

	// Field widths of the request and response transactions.
	localparam int unsigned SAMPLES_W   = 16;
	localparam int unsigned PAD_W       = 16;
	localparam int unsigned TOTAL_W     = 18;
	localparam int unsigned NEW_PAD_W   = 18;
	localparam int unsigned SIZE_W      = 19;

	// Default upper bound of the search.
	localparam int unsigned DEF_SIZE_LIMIT = 262144;

	// Program counter of the control store.
	localparam int unsigned PC_W = 3;
	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t PC_WAIT   = 3'd0;
	localparam pc_t PC_BOUND  = 3'd1;
	localparam pc_t PC_DIV2   = 3'd2;
	localparam pc_t PC_DIV3   = 3'd3;
	localparam pc_t PC_DIV5   = 3'd4;
	localparam pc_t PC_DIV7   = 3'd5;
	localparam pc_t PC_CHECK  = 3'd6;
	localparam pc_t PC_FINISH = 3'd7;

	// Micro-operations of the datapath.
	typedef enum logic [2:0] {
		UOP_WAIT,
		UOP_BOUND,
		UOP_DIV,
		UOP_CHECK,
		UOP_FINISH
	} uop_t;

	// Divisor select for the constant divider.
	typedef enum logic [1:0] {
		DIV_2,
		DIV_3,
		DIV_5,
		DIV_7
	} div_sel_t;

	// One control word of the program.
	typedef struct packed {
		uop_t     op;
		div_sel_t sel;
		pc_t      on_true;
		pc_t      on_false;
	} ctrl_t;

	// Datapath conditions that the sequencer branches on.
	typedef struct packed {
		logic in_taken;
		logic over_limit;
		logic divisible;
		logic unit_found;
		logic out_free;
	} cond_t;

	// Sequencer view handed to the datapath.
	typedef struct packed {
		pc_t   pc;
		ctrl_t ctrl;
		logic  hit;
	} seq_t;

endpackage

// ----- hdl/fsp_if.sv -----
// Handshake interfaces for the request and response channels.
// Depends on fsp_pkg for the field widths.
interface fsp_req_if import fsp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [SAMPLES_W-1:0] samples;
	logic [PAD_W-1:0]     low_pad;
	logic [PAD_W-1:0]     high_pad;

	modport source (output valid, samples, low_pad, high_pad, input ready);
	modport sink (input valid, samples, low_pad, high_pad, output ready);
endinterface

interface fsp_rsp_if import fsp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [NEW_PAD_W-1:0] new_low_pad;
	logic [NEW_PAD_W-1:0] new_high_pad;
	logic [SIZE_W-1:0]    padded_size;

	modport source (output valid, new_low_pad, new_high_pad, padded_size, input ready);
	modport sink (input valid, new_low_pad, new_high_pad, padded_size, output ready);
endinterface

// ----- hdl/fsp_const_div.sv -----
// Divider by a small constant (2, 3, 5 or 7) using a reciprocal multiply.
// Depends on fsp_pkg for the divisor select type.
module fsp_const_div import fsp_pkg::*; #(
	parameter int unsigned CAND_W = 19
) (
	input  logic [CAND_W-1:0] x,
	input  div_sel_t          sel,
	output logic [CAND_W-1:0] quot,
	output logic              divisible
);

	// Reciprocals ceil(2^SHIFT / k) are exact for every x below 2^CAND_W.
	localparam int unsigned     SHIFT  = CAND_W + 3;
	localparam int unsigned     PROD_W = CAND_W + SHIFT;
	localparam int unsigned     QK_W   = CAND_W + 3;
	localparam longint unsigned ONE_S  = 64'd1 << SHIFT;
	localparam logic [SHIFT-1:0] MUL_2 = SHIFT'(ONE_S / 64'd2);
	localparam logic [SHIFT-1:0] MUL_3 = SHIFT'((ONE_S + 64'd2) / 64'd3);
	localparam logic [SHIFT-1:0] MUL_5 = SHIFT'((ONE_S + 64'd4) / 64'd5);
	localparam logic [SHIFT-1:0] MUL_7 = SHIFT'((ONE_S + 64'd6) / 64'd7);

	logic [SHIFT-1:0]  mul;
	logic [PROD_W-1:0] prod;
	logic [QK_W-1:0]   q_ext;
	logic [QK_W-1:0]   qk;

	// Reciprocal selection.
	always_comb begin
		unique case (sel)
			DIV_2:   mul = MUL_2;
			DIV_3:   mul = MUL_3;
			DIV_5:   mul = MUL_5;
			DIV_7:   mul = MUL_7;
			default: mul = MUL_2;
		endcase
	end

	assign prod  = PROD_W'(x) * PROD_W'(mul);
	assign quot  = prod[SHIFT +: CAND_W];
	assign q_ext = QK_W'(quot);

	// Multiply the quotient back by shift and add (shift and subtract for 7) to test for a zero remainder.
	always_comb begin
		unique case (sel)
			DIV_2:   qk = q_ext << 1;
			DIV_3:   qk = q_ext + (q_ext << 1);
			DIV_5:   qk = q_ext + (q_ext << 2);
			DIV_7:   qk = (q_ext << 3) - q_ext;
			default: qk = q_ext << 1;
		endcase
	end

	assign divisible = (qk == QK_W'(x));

endmodule

// ----- hdl/fsp_sequencer.sv -----
// Microcode sequencer: program counter, control store and branch selection.
// Depends on fsp_pkg for the control word and condition types.
module fsp_sequencer import fsp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cond_t cond,
	output seq_t  seq
);

	pc_t   pc_q;
	ctrl_t ctrl;
	logic  hit;

	// Control store: one word per step.
	always_comb begin
		unique case (pc_q)
			PC_WAIT:   ctrl = '{op: UOP_WAIT,   sel: DIV_2, on_true: PC_BOUND,  on_false: PC_WAIT};
			PC_BOUND:  ctrl = '{op: UOP_BOUND,  sel: DIV_2, on_true: PC_FINISH, on_false: PC_DIV2};
			PC_DIV2:   ctrl = '{op: UOP_DIV,    sel: DIV_2, on_true: PC_DIV2,   on_false: PC_DIV3};
			PC_DIV3:   ctrl = '{op: UOP_DIV,    sel: DIV_3, on_true: PC_DIV3,   on_false: PC_DIV5};
			PC_DIV5:   ctrl = '{op: UOP_DIV,    sel: DIV_5, on_true: PC_DIV5,   on_false: PC_DIV7};
			PC_DIV7:   ctrl = '{op: UOP_DIV,    sel: DIV_7, on_true: PC_DIV7,   on_false: PC_CHECK};
			PC_CHECK:  ctrl = '{op: UOP_CHECK,  sel: DIV_2, on_true: PC_FINISH, on_false: PC_BOUND};
			PC_FINISH: ctrl = '{op: UOP_FINISH, sel: DIV_2, on_true: PC_WAIT,   on_false: PC_FINISH};
			default:   ctrl = '{op: UOP_WAIT,   sel: DIV_2, on_true: PC_WAIT,   on_false: PC_WAIT};
		endcase
	end

	// Branch condition chosen by the micro-operation.
	always_comb begin
		unique case (ctrl.op)
			UOP_WAIT:   hit = cond.in_taken;
			UOP_BOUND:  hit = cond.over_limit;
			UOP_DIV:    hit = cond.divisible;
			UOP_CHECK:  hit = cond.unit_found;
			UOP_FINISH: hit = cond.out_free;
			default:    hit = 1'b0;
		endcase
	end

	// Program counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT;
		end else begin
			pc_q <= hit ? ctrl.on_true : ctrl.on_false;
		end
	end

	assign seq = '{pc: pc_q, ctrl: ctrl, hit: hit};

endmodule

// ----- hdl/fft_size_pad_split.sv -----
// Channel    Dir  Fields                                        Transaction when
// req        in   samples, low_pad, high_pad                    req.valid && req.ready
// rsp        out  new_low_pad, new_high_pad, padded_size        rsp.valid && rsp.ready
//
// After its acceptance, one request runs a loop over candidates: a bound check, then the
// constant divisions by 2, 3, 5 and 7, each repeated while it divides, then a check whether
// 1 is left. A last bound check ends the loop when no fast length lies within the limit.
// The microcode loop over candidates does one constant division per cycle.
// A request is taken only in the wait step; a finished response waits in an output
// register, so the next request can be taken while the previous response is stalled.
// Reset is asynchronous and active low; it returns the sequencer to the wait step.
//
// Top level of the padded FFT size block: datapath, output register and assertions.
// Depends on fsp_pkg, fsp_if, fsp_sequencer, fsp_const_div and assert_macros.svh.
`include "assert_macros.svh"

module fft_size_pad_split import fsp_pkg::*; #(
	parameter int unsigned SIZE_LIMIT = DEF_SIZE_LIMIT
) (
	input  logic      clk,
	input  logic      arst_n,
	fsp_req_if.sink   req,
	fsp_rsp_if.source rsp
);

	// The candidate must hold the total and one past the limit.
	localparam int unsigned LIM_W  = $clog2(SIZE_LIMIT + 2);
	localparam int unsigned CAND_W = (LIM_W > TOTAL_W) ? LIM_W : TOTAL_W;

	seq_t  seq;
	cond_t cond;

	logic [PAD_W-1:0]     low_q;
	logic [PAD_W-1:0]     high_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [CAND_W-1:0]    cand_q;
	logic [CAND_W-1:0]    x_q;
	logic [SIZE_W-1:0]    size_q;
	logic                 out_valid_q;
	logic [NEW_PAD_W-1:0] out_low_q;
	logic [NEW_PAD_W-1:0] out_high_q;
	logic [SIZE_W-1:0]    out_size_q;

	logic [TOTAL_W-1:0] sum;
	logic [CAND_W-1:0]  quot;
	logic               divisible;
	logic               in_taken;
	logic               out_free;
	logic [SIZE_W-1:0]  extra;
	logic [SIZE_W-1:0]  extra_lo;
	logic [SIZE_W-1:0]  low_sum;
	logic [SIZE_W-1:0]  high_sum;

	fsp_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cond   (cond),
		.seq    (seq)
	);

	fsp_const_div #(
		.CAND_W (CAND_W)
	) u_div (
		.x         (x_q),
		.sel       (seq.ctrl.sel),
		.quot      (quot),
		.divisible (divisible)
	);

	// Handshakes and branch conditions.
	assign req.ready = (seq.ctrl.op == UOP_WAIT);
	assign in_taken  = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	assign cond = '{
		in_taken:   in_taken,
		over_limit: (cand_q > CAND_W'(SIZE_LIMIT)),
		divisible:  divisible,
		unit_found: (x_q == CAND_W'(1)),
		out_free:   out_free
	};

	// Total length and the split of the added length.
	assign sum      = TOTAL_W'(req.samples) + TOTAL_W'(req.low_pad) + TOTAL_W'(req.high_pad);
	assign extra    = size_q - SIZE_W'(total_q);
	assign extra_lo = extra >> 1;
	assign low_sum  = SIZE_W'(low_q) + extra_lo;
	assign high_sum = SIZE_W'(high_q) + (extra - extra_lo);

	// Datapath registers driven by the current micro-operation.
	always_ff @(posedge clk) begin
		case (seq.ctrl.op)
			UOP_WAIT: begin
				if (in_taken) begin
					low_q   <= req.low_pad;
					high_q  <= req.high_pad;
					total_q <= sum;
					cand_q  <= (sum == '0) ? CAND_W'(1) : CAND_W'(sum);
				end
			end
			UOP_BOUND: begin
				x_q <= cand_q;
				if (seq.hit) begin
					size_q <= SIZE_W'(total_q);
				end
			end
			UOP_DIV: begin
				if (seq.hit) begin
					x_q <= quot;
				end
			end
			UOP_CHECK: begin
				if (seq.hit) begin
					size_q <= SIZE_W'(cand_q);
				end else begin
					cand_q <= cand_q + CAND_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (seq.ctrl.op == UOP_FINISH && seq.hit) begin
			out_low_q  <= low_sum[NEW_PAD_W-1:0];
			out_high_q <= high_sum[NEW_PAD_W-1:0];
			out_size_q <= size_q;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq.ctrl.op == UOP_FINISH && seq.hit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.new_low_pad  = out_low_q;
	assign rsp.new_high_pad = out_high_q;
	assign rsp.padded_size  = out_size_q;

	// A taken request always starts the candidate loop at the bound check.
	`ASSERT_NEXT(a_accept_to_bound, req.valid && req.ready, seq.pc == PC_BOUND)

	// The value being factored is never zero during division.
	`ASSERT_SAME(a_div_nonzero, seq.ctrl.op == UOP_DIV, x_q != '0)

	// The chosen size never falls below the total.
	`ASSERT_SAME(a_size_covers, seq.ctrl.op == UOP_FINISH, size_q >= SIZE_W'(total_q))

	// Leaving the finish step always presents a response.
	`ASSERT_NEXT(a_finish_loads, seq.ctrl.op == UOP_FINISH && seq.hit, rsp.valid)

endmodule
